// ----- design/qtci_pkg.sv -----
`default_nettype none

package qtci_pkg;

    localparam int COORD_W    = 24;
    localparam int OFFSET_W   = COORD_W + 1;
    localparam int PROD_W     = 2 * OFFSET_W;
    localparam int FRAC_SHIFT = 32;
    localparam int INDEX_W    = 13;
    localparam int DEPTH_W    = 3;
    localparam int CALC_DEPTH_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0]
    {
        REG_REGION_LEFT = 2'd0,
        REG_REGION_TOP  = 2'd1,
        REG_X_SCALE     = 2'd2,
        REG_Y_SCALE     = 2'd3
    } qtci_reg_t;

    typedef struct packed
    {
        logic offset_en;
        logic product_en;
        logic cell_en;
    } qtci_stage_en_t;

endpackage

`default_nettype wire

// ----- design/qtci_cell_map.sv -----
`default_nettype none

module qtci_cell_map
    import qtci_pkg::*;
#(
    parameter int LEVELS = 6
)
(
    input  wire logic                 clk,
    input  wire qtci_stage_en_t       en,
    input  wire logic [COORD_W-1:0]   coord,
    input  wire logic [COORD_W-1:0]   origin,
    input  wire logic [COORD_W-1:0]   scale,
    output logic      [LEVELS-1:0]    cell_idx,
    output logic                      saturated
);

    logic signed [OFFSET_W-1:0] offset_next;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [PROD_W-1:0]   offset_ext;
    logic signed [PROD_W-1:0]   scale_ext;
    logic signed [PROD_W-1:0]   product_next;
    logic signed [PROD_W-1:0]   product_reg;
    logic        [LEVELS-1:0]   cell_next;
    logic        [LEVELS-1:0]   cell_reg;
    logic                       sat_next;
    logic                       sat_reg;

    assign offset_next = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});
    assign offset_ext   = {{(PROD_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
    assign scale_ext    = {{(PROD_W-COORD_W){1'b0}}, scale};
    assign product_next = offset_ext * scale_ext;

    // negative -> cell 0; above the last cell -> last cell
    always_comb
    begin
        if (product_reg[PROD_W-1])
        begin
            cell_next = '0;
            sat_next  = 1'b1;
        end
        else if (|product_reg[PROD_W-2:FRAC_SHIFT+LEVELS])
        begin
            cell_next = '1;
            sat_next  = 1'b1;
        end
        else
        begin
            cell_next = product_reg[FRAC_SHIFT +: LEVELS];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.offset_en)
        begin
            offset_reg <= offset_next;
        end
        if (en.product_en)
        begin
            product_reg <= product_next;
        end
        if (en.cell_en)
        begin
            cell_reg <= cell_next;
            sat_reg  <= sat_next;
        end
    end

    assign cell_idx  = cell_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ----- design/quadtree_cell_index.sv -----
// Quadtree cell index: maps an axis-aligned box to its linear quadtree cell.
// Input stream s_*: one request per box, s_tdata holds box_left, box_top,
// box_right, box_bottom (24-bit signed Q15.8 each). Output stream m_*: one
// request per box, in order, m_tdata holds cell_index, tree_depth and
// out_of_region. Region origin and scales are set over the APB port
// (region_left 0x0, region_top 0x4, x_scale 0x8, y_scale 0xC); write them
// only while no box is in flight.
// Pipeline: offset, multiply, saturate and Morton/level stages, each one
// registered, the last driving m_tvalid; a 25x25 multiply per coordinate
// sets the stage depth. Throughput is one box per cycle if m_tready is high.
// When m_tready is low the output register holds its request and the
// stages behind it keep filling; s_tready falls once all four stages are
// full, so nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the default region and scale
// registers.
`default_nettype none

module quadtree_cell_index
    import qtci_pkg::*;
#(
    parameter int LEVELS = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [23:0] box_left, [47:24] box_top, [71:48] box_right, [95:72] box_bottom
    input  wire logic [95:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [12:0] cell_index, [15:13] tree_depth, [16] out_of_region, [23:17] zero
    output logic      [23:0]           m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int LVL_W = $clog2(LEVELS + 1);
    localparam int IDX_W = (2 * LEVELS + 1 > INDEX_W) ? 2 * LEVELS + 1 : INDEX_W;

    logic [COORD_W-1:0] region_left_reg;
    logic [COORD_W-1:0] region_top_reg;
    logic [COORD_W-1:0] x_scale_reg;
    logic [COORD_W-1:0] y_scale_reg;

    qtci_reg_t reg_sel;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = qtci_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_left_reg <= COORD_W'(-128000);
            region_top_reg  <= COORD_W'(-1280000);
            x_scale_reg     <= COORD_W'(1073742);
            y_scale_reg     <= COORD_W'(107374);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_REGION_LEFT: region_left_reg <= pwdata[COORD_W-1:0];
                REG_REGION_TOP:  region_top_reg  <= pwdata[COORD_W-1:0];
                REG_X_SCALE:     x_scale_reg     <= pwdata[COORD_W-1:0];
                REG_Y_SCALE:     y_scale_reg     <= pwdata[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_REGION_LEFT: prdata = APB_DATA_W'(region_left_reg);
            REG_REGION_TOP:  prdata = APB_DATA_W'(region_top_reg);
            REG_X_SCALE:     prdata = APB_DATA_W'(x_scale_reg);
            REG_Y_SCALE:     prdata = APB_DATA_W'(y_scale_reg);
            default:         prdata = '0;
        endcase
    end

    // stage valids and backpressure
    logic           valid1_reg;
    logic           valid2_reg;
    logic           valid3_reg;
    logic           valid4_reg;
    logic           en1;
    logic           en2;
    logic           en3;
    logic           en4;
    qtci_stage_en_t stage_en;

    assign en4 = !valid4_reg || m_tready;
    assign en3 = !valid3_reg || en4;
    assign en2 = !valid2_reg || en3;
    assign en1 = !valid1_reg || en2;
    assign s_tready = en1;

    assign stage_en.offset_en  = en1;
    assign stage_en.product_en = en2;
    assign stage_en.cell_en    = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                valid1_reg <= s_tvalid;
            end
            if (en2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (en3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (en4)
            begin
                valid4_reg <= valid3_reg;
            end
        end
    end

    logic [LEVELS-1:0] x0;
    logic [LEVELS-1:0] y0;
    logic [LEVELS-1:0] x1;
    logic [LEVELS-1:0] y1;
    logic [3:0]        sat;

    qtci_cell_map #(.LEVELS(LEVELS)) u_map_left
    (
        .clk(clk), .en(stage_en), .coord(s_tdata[23:0]),
        .origin(region_left_reg), .scale(x_scale_reg), .cell_idx(x0), .saturated(sat[0])
    );

    qtci_cell_map #(.LEVELS(LEVELS)) u_map_top
    (
        .clk(clk), .en(stage_en), .coord(s_tdata[47:24]),
        .origin(region_top_reg), .scale(y_scale_reg), .cell_idx(y0), .saturated(sat[1])
    );

    qtci_cell_map #(.LEVELS(LEVELS)) u_map_right
    (
        .clk(clk), .en(stage_en), .coord(s_tdata[71:48]),
        .origin(region_left_reg), .scale(x_scale_reg), .cell_idx(x1), .saturated(sat[2])
    );

    qtci_cell_map #(.LEVELS(LEVELS)) u_map_bottom
    (
        .clk(clk), .en(stage_en), .coord(s_tdata[95:72]),
        .origin(region_top_reg), .scale(y_scale_reg), .cell_idx(y1), .saturated(sat[3])
    );

    // Morton interleave, level search, linear index
    logic [2*LEVELS-1:0]  lt_code;
    logic [2*LEVELS-1:0]  rb_code;
    logic [2*LEVELS-1:0]  diff;
    logic [LVL_W-1:0]     climb;
    logic [CALC_DEPTH_W-1:0] depth_calc;
    logic [IDX_W-1:0]     offset_cells;
    logic [IDX_W-1:0]     index_calc;
    logic [INDEX_W-1:0]   index_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [DEPTH_W-1:0]   depth_reg;
    logic                 oor_next;
    logic                 oor_reg;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            lt_code[2*i]   = x0[i];
            lt_code[2*i+1] = y0[i];
            rb_code[2*i]   = x1[i];
            rb_code[2*i+1] = y1[i];
        end
        diff = lt_code ^ rb_code;

        climb = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (diff[2*i +: 2] != 2'b00)
            begin
                climb = LVL_W'(i + 1);
            end
        end
        depth_calc = CALC_DEPTH_W'(LEVELS) - CALC_DEPTH_W'(climb);

        // (4^depth - 1) / 3 is 0101..01 with depth ones
        offset_cells = '0;
        for (int j = 0; j < LEVELS; j++)
        begin
            if (j < int'(depth_calc))
            begin
                offset_cells[2*j] = 1'b1;
            end
        end

        index_calc = IDX_W'(rb_code >> {climb, 1'b0}) + offset_cells;
        index_next = index_calc[INDEX_W-1:0];
        depth_next = depth_calc[DEPTH_W-1:0];
        oor_next   = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            index_reg <= index_next;
            depth_reg <= depth_next;
            oor_reg   <= oor_next;
        end
    end

    assign m_tvalid = valid4_reg;
    assign m_tdata  = {7'd0, oor_reg, depth_reg, index_reg};

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output is not blocked");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid1_reg)
        else $error("accepted request did not enter the first stage");

    a_stage3_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid3_reg && en4) |=> m_tvalid)
        else $error("request lost between saturate stage and output");

endmodule

`default_nettype wire
